@@ sv/hed_pkg.sv @@
// ----------------------------------------------------------------------------
// hed_pkg
// Types, character codes and the named reference table of the decoder.
// ----------------------------------------------------------------------------
package hed_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       stream_end;
    logic       run_last;
  } out_item_t;

  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LOW_X = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;

  localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF8_LEAD4 = 8'hF0;
  localparam logic [7:0] UTF8_CONT  = 8'h80;
  localparam logic [5:0] UTF8_MASK  = 6'h3F;

  localparam int          ACC_W     = 42;
  localparam int          SUM_W     = 47;
  localparam logic [20:0] CP_LIMIT  = 21'h10FFFF;
  localparam int          NAMED_NUM = 12;
  localparam int          NAMED_LEN = 6;

  typedef logic [NAMED_LEN-1:0][7:0] name_t;

  typedef struct packed {
    logic [2:0]  len;
    name_t       text;
    logic [20:0] cp;
  } named_ref_t;

  typedef struct packed {
    logic        hit;
    logic [20:0] cp;
  } named_hit_t;

  // text holds the first character in the lowest byte
  localparam named_ref_t NAMED_TABLE [NAMED_NUM] = '{
    '{3'd3, {24'h0, "pma"},    21'h00026},
    '{3'd2, {32'h0, "tl"},     21'h0003C},
    '{3'd2, {32'h0, "tg"},     21'h0003E},
    '{3'd4, {16'h0, "touq"},   21'h00022},
    '{3'd4, {16'h0, "sopa"},   21'h00027},
    '{3'd4, {16'h0, "psbn"},   21'h00020},
    '{3'd3, {24'h0, "93#"},    21'h00027},
    '{3'd5, {8'h0,  "hsadm"},  21'h02014},
    '{3'd5, {8'h0,  "hsadn"},  21'h02013},
    '{3'd6, "pilleh",          21'h02026},
    '{3'd4, {16'h0, "ypoc"},   21'h000A9},
    '{3'd3, {24'h0, "ger"},    21'h000AE}
  };

  typedef enum logic [3:0] {
    S_IDLE, S_FL_NAME, S_FL_END, S_RES_INIT, S_RES_DIGIT, S_RES_SEL, S_UTF8,
    S_EC_AMP, S_EC_NAME, S_EC_SEMI, S_RESCAN, S_RESCAN_B
  } state_t;

  typedef enum logic [2:0] {
    DP_NOP, DP_FEED, DP_FEED_INC, DP_IDX_CLR, DP_IDX_INC, DP_CLEAR,
    DP_RES_INIT, DP_DIGIT
  } dp_op_t;

  typedef enum logic [1:0] {
    SRC_IN, SRC_HELD, SRC_B
  } src_t;

  typedef enum logic [2:0] {
    EM_FEED, EM_AMP, EM_NAME, EM_SEMI, EM_END, EM_UTF8
  } emit_sel_t;

  typedef struct packed {
    dp_op_t    op;
    logic      sel_cp;
    src_t      src;
    logic      emit;
    emit_sel_t sel;
    logic      last;
  } cmd_t;

  typedef struct packed {
    logic pend;
    logic full;
    logic len_zero;
    logic idx_end;
    logic idx_last_slot;
    logic out_free;
    logic in_eot;
    logic in_amp;
    logic in_semi;
    logic held_amp;
    logic b_amp;
    logic buf0_amp;
    logic amp_after;
    logic named_hit;
    logic num_none;
    logic use_utf8;
    logic seq_last;
  } sts_t;

  function automatic named_hit_t named_lookup(input name_t nm, input logic [2:0] len);
    named_hit_t r;
    logic       eq;
    r = '0;
    for (int e = 0; e < NAMED_NUM; e++) begin
      eq = (NAMED_TABLE[e].len == len);
      for (int p = 0; p < NAMED_LEN; p++) begin
        if (p < int'(NAMED_TABLE[e].len) && nm[p] != NAMED_TABLE[e].text[p]) begin
          eq = 1'b0;
        end
      end
      if (eq && !r.hit) begin
        r.hit = 1'b1;
        r.cp  = NAMED_TABLE[e].cp;
      end
    end
    return r;
  endfunction

endpackage

@@ sv/hed_dp.sv @@
// ----------------------------------------------------------------------------
// hed_dp
// Datapath: name window, reference state, numeric parser, UTF-8 encoder and
// output register.
// ----------------------------------------------------------------------------
module hed_dp #(
  parameter int REF_WINDOW = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  hed_pkg::in_item_t  in_data,
  input  hed_pkg::cmd_t      cmd,
  input  logic               out_ready,
  output hed_pkg::sts_t      sts,
  output logic               out_valid,
  output hed_pkg::out_item_t out_data
);
  import hed_pkg::*;

  localparam int NAME_MAX = REF_WINDOW - 1;
  localparam int IW       = $clog2(NAME_MAX);
  localparam int LW       = $clog2(REF_WINDOW);

  logic [7:0]              buf_r [NAME_MAX];
  logic                    pend_r, pend_nxt;
  logic [LW-1:0]           len_r, len_nxt;
  logic [IW-1:0]           idx_r, idx_nxt;
  logic [7:0]              b_r, b_nxt;
  logic                    hex_r, hex_nxt;
  logic                    ok_r, ok_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic [20:0]             cp_r, cp_nxt;
  logic [1:0]              nb_r, nb_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_item_t               out_r, out_nxt;

  logic                    wr_en;
  logic [IW-1:0]           wr_idx;
  logic [7:0]              feed_byte, held, c_lc, utf8_byte;
  logic                    full, amp_after, b0_hash, is_x, hex_sel, dec_sel, in_range;
  name_t                   nm;
  named_hit_t              nh;
  logic [20:0]             cp_sel, cp_sh;
  logic [1:0]              nb_sel, rem;
  logic signed [9:0]       dig;
  logic signed [SUM_W-1:0] wide, prod, sum;

  assign held = buf_r[idx_r];
  assign full = (int'(len_r) == NAME_MAX);

  always_comb begin
    case (cmd.src)
      SRC_HELD: feed_byte = held;
      SRC_B:    feed_byte = b_r;
      default:  feed_byte = in_data.in_byte;
    endcase
  end

  always_comb begin
    amp_after = 1'b0;
    for (int j = 0; j < NAME_MAX; j++) begin
      if (j == int'(idx_r) + 1 && buf_r[j] == CH_AMP) amp_after = 1'b1;
    end
  end

  for (genvar p = 0; p < NAMED_LEN; p++) begin : g_nm
    if (p < NAME_MAX) begin : g_tap
      assign nm[p] = buf_r[p];
    end else begin : g_pad
      assign nm[p] = 8'h00;
    end
  end

  assign nh = named_lookup(nm, (int'(len_r) > NAMED_LEN) ? 3'd7 : 3'(len_r));

  assign b0_hash = (len_r != '0) && (buf_r[0] == CH_HASH);
  assign is_x    = (buf_r[1] == CH_LOW_X) || (buf_r[1] == CH_UP_X);
  assign hex_sel = b0_hash && (int'(len_r) > 2) && is_x;
  assign dec_sel = b0_hash && !hex_sel && (int'(len_r) > 1);

  // digit value of the held byte
  always_comb begin
    c_lc = held;
    if (held >= CH_UP_A && held <= CH_UP_Z) c_lc = held + 8'd32;
    if (held >= CH_ZERO && held <= CH_NINE) begin
      dig = $signed({2'b00, held}) - 10'sd48;
    end else begin
      dig = $signed({2'b00, c_lc}) - 10'sd87;
    end
    wide = SUM_W'(acc_r);
    prod = hex_r ? (wide <<< 4) : ((wide <<< 3) + (wide <<< 1));
    sum  = prod + {{(SUM_W-10){dig[9]}}, dig};
  end

  assign in_range = ok_r && (acc_r >= 0) && (acc_r <= $signed(ACC_W'(CP_LIMIT)));
  assign cp_sel   = nh.hit ? nh.cp : acc_r[20:0];

  always_comb begin
    if (cp_sel < 21'h80)         nb_sel = 2'd0;
    else if (cp_sel < 21'h800)   nb_sel = 2'd1;
    else if (cp_sel < 21'h10000) nb_sel = 2'd2;
    else                         nb_sel = 2'd3;
  end

  always_comb begin
    rem = nb_r - idx_r[1:0];
    case (rem)
      2'd0:    cp_sh = cp_r;
      2'd1:    cp_sh = cp_r >> 6;
      2'd2:    cp_sh = cp_r >> 12;
      default: cp_sh = cp_r >> 18;
    endcase
    if (idx_r == '0) begin
      case (nb_r)
        2'd1:    utf8_byte = UTF8_LEAD2 | cp_sh[7:0];
        2'd2:    utf8_byte = UTF8_LEAD3 | cp_sh[7:0];
        2'd3:    utf8_byte = UTF8_LEAD4 | cp_sh[7:0];
        default: utf8_byte = cp_sh[7:0];
      endcase
    end else begin
      utf8_byte = UTF8_CONT | {2'b00, cp_sh[5:0] & UTF8_MASK};
    end
  end

  always_comb begin
    pend_nxt = pend_r;
    len_nxt  = len_r;
    idx_nxt  = idx_r;
    b_nxt    = b_r;
    hex_nxt  = hex_r;
    ok_nxt   = ok_r;
    acc_nxt  = acc_r;
    cp_nxt   = cp_r;
    nb_nxt   = nb_r;
    wr_en    = 1'b0;
    wr_idx   = len_r[IW-1:0];
    case (cmd.op)
      DP_FEED, DP_FEED_INC: begin
        if (cmd.op == DP_FEED_INC) idx_nxt = idx_r + 1'b1;
        if (!pend_r) begin
          if (feed_byte == CH_AMP) begin
            pend_nxt = 1'b1;
            len_nxt  = '0;
          end
        end else if (feed_byte == CH_SEMI) begin
          len_nxt = len_r;
        end else if (!full) begin
          wr_en   = 1'b1;
          len_nxt = len_r + 1'b1;
        end else begin
          pend_nxt = 1'b0;
          len_nxt  = '0;
          b_nxt    = feed_byte;
          idx_nxt  = '0;
        end
      end
      DP_IDX_CLR: idx_nxt = '0;
      DP_IDX_INC: idx_nxt = idx_r + 1'b1;
      DP_CLEAR: begin
        pend_nxt = 1'b0;
        len_nxt  = '0;
      end
      DP_RES_INIT: begin
        hex_nxt = hex_sel;
        ok_nxt  = hex_sel || dec_sel;
        acc_nxt = '0;
        idx_nxt = hex_sel ? IW'(2) : IW'(1);
      end
      DP_DIGIT: begin
        idx_nxt = idx_r + 1'b1;
        if (!hex_r && (held < CH_ZERO || held > CH_NINE)) ok_nxt = 1'b0;
        if (sum > (SUM_W'(1) <<< 40))       acc_nxt = ACC_W'(1) <<< 40;
        else if (sum < -(SUM_W'(1) <<< 40)) acc_nxt = -(ACC_W'(1) <<< 40);
        else                                acc_nxt = ACC_W'(sum);
      end
      default: pend_nxt = pend_r;
    endcase
    if (cmd.sel_cp) begin
      cp_nxt  = cp_sel;
      nb_nxt  = nb_sel;
      idx_nxt = '0;
    end
  end

  always_comb begin
    out_nxt          = out_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    if (cmd.emit) begin
      out_valid_nxt       = 1'b1;
      out_nxt.has_byte    = 1'b1;
      out_nxt.stream_end  = 1'b0;
      out_nxt.run_last    = cmd.last;
      case (cmd.sel)
        EM_AMP:  out_nxt.out_byte = CH_AMP;
        EM_NAME: out_nxt.out_byte = held;
        EM_SEMI: out_nxt.out_byte = CH_SEMI;
        EM_UTF8: out_nxt.out_byte = utf8_byte;
        EM_END: begin
          out_nxt.out_byte   = 8'h00;
          out_nxt.has_byte   = 1'b0;
          out_nxt.stream_end = 1'b1;
        end
        default: out_nxt.out_byte = feed_byte;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      len_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      len_r       <= len_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    b_r   <= b_nxt;
    hex_r <= hex_nxt;
    ok_r  <= ok_nxt;
    acc_r <= acc_nxt;
    cp_r  <= cp_nxt;
    nb_r  <= nb_nxt;
    out_r <= out_nxt;
    if (wr_en) buf_r[wr_idx] <= feed_byte;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign sts.pend          = pend_r;
  assign sts.full          = full;
  assign sts.len_zero      = (len_r == '0);
  assign sts.idx_end       = ((LW'(idx_r) + LW'(1)) == len_r);
  assign sts.idx_last_slot = (int'(idx_r) == NAME_MAX - 1);
  assign sts.out_free      = !out_valid_r || out_ready;
  assign sts.in_eot        = in_data.end_of_text;
  assign sts.in_amp        = (in_data.in_byte == CH_AMP);
  assign sts.in_semi       = (in_data.in_byte == CH_SEMI);
  assign sts.held_amp      = (held == CH_AMP);
  assign sts.b_amp         = (b_r == CH_AMP);
  assign sts.buf0_amp      = (buf_r[0] == CH_AMP);
  assign sts.amp_after     = amp_after;
  assign sts.named_hit     = nh.hit;
  assign sts.num_none      = !(hex_sel || dec_sel);
  assign sts.use_utf8      = nh.hit || in_range;
  assign sts.seq_last      = (idx_r == IW'(nb_r));

endmodule

@@ sv/hed_ctrl.sv @@
// ----------------------------------------------------------------------------
// hed_ctrl
// Controller: sequences feeding, resolving, echoing, flushing and rescanning.
// ----------------------------------------------------------------------------
module hed_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  hed_pkg::sts_t sts,
  output logic          in_ready,
  output hed_pkg::cmd_t cmd
);
  import hed_pkg::*;

  state_t state_r, state_nxt;
  logic   fire;

  assign fire = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (fire) begin
          if (sts.in_eot) begin
            if (sts.pend) state_nxt = sts.len_zero ? S_FL_END : S_FL_NAME;
          end else if (sts.pend && sts.in_semi) begin
            state_nxt = S_RES_INIT;
          end else if (sts.pend && sts.full) begin
            state_nxt = S_RESCAN;
          end
        end
      end
      S_FL_NAME:   if (sts.out_free && sts.idx_end) state_nxt = S_FL_END;
      S_FL_END:    if (sts.out_free) state_nxt = S_IDLE;
      S_RES_INIT:  state_nxt = (sts.named_hit || sts.num_none) ? S_RES_SEL : S_RES_DIGIT;
      S_RES_DIGIT: if (sts.idx_end) state_nxt = S_RES_SEL;
      S_RES_SEL:   state_nxt = sts.use_utf8 ? S_UTF8 : S_EC_AMP;
      S_UTF8:      if (sts.out_free && sts.seq_last) state_nxt = S_IDLE;
      S_EC_AMP:    if (sts.out_free) state_nxt = sts.len_zero ? S_EC_SEMI : S_EC_NAME;
      S_EC_NAME:   if (sts.out_free && sts.idx_end) state_nxt = S_EC_SEMI;
      S_EC_SEMI:   if (sts.out_free) state_nxt = S_IDLE;
      S_RESCAN: begin
        if ((sts.pend || sts.held_amp || sts.out_free) && sts.idx_last_slot)
          state_nxt = S_RESCAN_B;
      end
      S_RESCAN_B:  if (sts.pend || sts.b_amp || sts.out_free) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.op     = DP_NOP;
    cmd.src    = SRC_IN;
    cmd.sel    = EM_FEED;
    unique case (state_r)
      S_IDLE: begin
        in_ready = sts.out_free;
        if (fire) begin
          if (sts.in_eot) begin
            cmd.emit = 1'b1;
            if (sts.pend) begin
              cmd.op  = DP_IDX_CLR;
              cmd.sel = EM_AMP;
            end else begin
              cmd.sel  = EM_END;
              cmd.last = 1'b1;
            end
          end else begin
            cmd.op = DP_FEED;
            if (!sts.pend && !sts.in_amp) begin
              cmd.emit = 1'b1;
              cmd.last = 1'b1;
            end else if (sts.pend && sts.full && !sts.in_semi) begin
              cmd.emit = 1'b1;
              cmd.sel  = EM_AMP;
              cmd.last = sts.buf0_amp;
            end
          end
        end
      end
      S_FL_NAME: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = EM_NAME;
          cmd.op   = DP_IDX_INC;
        end
      end
      S_FL_END: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = EM_END;
          cmd.last = 1'b1;
          cmd.op   = DP_CLEAR;
        end
      end
      S_RES_INIT:  cmd.op = DP_RES_INIT;
      S_RES_DIGIT: begin
        cmd.op  = DP_DIGIT;
        cmd.src = SRC_HELD;
      end
      S_RES_SEL:   cmd.sel_cp = 1'b1;
      S_UTF8: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = EM_UTF8;
          cmd.last = sts.seq_last;
          cmd.op   = sts.seq_last ? DP_CLEAR : DP_IDX_INC;
        end
      end
      S_EC_AMP: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = EM_AMP;
          cmd.op   = DP_IDX_CLR;
        end
      end
      S_EC_NAME: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = EM_NAME;
          cmd.op   = DP_IDX_INC;
        end
      end
      S_EC_SEMI: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = EM_SEMI;
          cmd.last = 1'b1;
          cmd.op   = DP_CLEAR;
        end
      end
      S_RESCAN: begin
        cmd.src = SRC_HELD;
        if (sts.pend || sts.held_amp) begin
          cmd.op = DP_FEED_INC;
        end else if (sts.out_free) begin
          cmd.op   = DP_FEED_INC;
          cmd.emit = 1'b1;
          cmd.last = sts.idx_last_slot ? sts.b_amp : sts.amp_after;
        end
      end
      S_RESCAN_B: begin
        cmd.src = SRC_B;
        if (sts.pend || sts.b_amp) begin
          cmd.op = DP_FEED;
        end else if (sts.out_free) begin
          cmd.op   = DP_FEED;
          cmd.emit = 1'b1;
          cmd.last = 1'b1;
        end
      end
      default: cmd.op = DP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ sv/html_entity_decoder.sv @@
// ----------------------------------------------------------------------------
// html_entity_decoder
// Streaming HTML character reference decoder with UTF-8 output.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready/in_data carries one text byte or an end of
// text mark per transaction. Output channel out_valid/out_ready/out_data
// carries one decoded byte or the bare end marker; run_last flags the last
// transaction caused by an input, stream_end flags the end marker.
// Plain bytes and bytes held into a reference name are handled on acceptance;
// a plain byte appears in the cycle after acceptance, and a new byte is taken
// every cycle while the output register drains and no sequence runs.
// A closing ';' runs a resolve sequence: a setup step, a step per numeric
// digit, a select step, then the emitted bytes in turn (UTF-8 sequence, or
// the echoed '&' name ';'). Window overflow emits '&' and then rescans the
// held bytes one per cycle. End of text flushes the open reference one byte
// per cycle before the end marker. The single output register and the
// byte-serial controller set this pace. While the output register holds a
// byte that out_ready has not taken, emitting steps hold and input is not
// accepted. Reset clears the open reference and the output valid flag.
// ----------------------------------------------------------------------------
module html_entity_decoder #(
  parameter int REF_WINDOW = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  hed_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output hed_pkg::out_item_t out_data
);
  import hed_pkg::*;

  cmd_t cmd;
  sts_t sts;

  hed_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  hed_dp #(
    .REF_WINDOW (REF_WINDOW)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_ready (out_ready),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("emit into occupied output register");

  a_end_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.stream_end |-> out_data.run_last && !out_data.has_byte)
    else $error("end marker malformed");

  a_accept_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> sts.out_free)
    else $error("input accepted with output blocked");
`endif

endmodule
